### sv/tws_pkg.sv
// Shared types and constants for the two-wheel speed matcher.
// No dependencies.
`timescale 1ns / 1ps

package tws_pkg;

  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SPEED_W = 8;
  localparam int CMD_W   = 3;
  localparam int OPV_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [SPEED_W-1:0] MIN_TURN_RESET = 8'd50;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TURN    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FLIP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_DIR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TOGGLE  = 3'd6;

  localparam logic [OPV_W-1:0] SIDE_NONE  = 2'd0;
  localparam logic [OPV_W-1:0] SIDE_LEFT  = 2'd1;
  localparam logic [OPV_W-1:0] SIDE_RIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN_SPEED = 1'd1;

endpackage

### sv/tws_divider.sv
// Restoring serial divider, one quotient bit per cycle; needs num < den.
// Depends on tws_pkg.
`timescale 1ns / 1ps

module tws_divider import tws_pkg::*; #(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [COUNT_WIDTH-1:0]   num,
  input  logic [COUNT_WIDTH-1:0]   den,
  output logic                     busy,
  output logic                     done,
  output logic [FRACTION_BITS-1:0] quot
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(FRACTION_BITS);

  logic [COUNT_WIDTH-1:0]   rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0]   den_r, den_nxt;
  logic [FRACTION_BITS-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  logic [COUNT_WIDTH:0] rem_sh;
  logic [COUNT_WIDTH:0] diff;
  logic                 fits;

  assign rem_sh = {rem_r, 1'b0};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = !diff[COUNT_WIDTH];

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      quot_nxt = '0;
      cnt_nxt  = STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      quot_nxt = {quot_r[FRACTION_BITS-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder out of range");

endmodule

### sv/two_wheel_speed_matcher_top.sv
// Top level of the two-wheel speed matcher: command decode, drive state, tick sequencer.
// Depends on tws_pkg and tws_divider.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_*): one command item per handshake. in_tuser carries the
//   command code; in_tdata carries operand and both encoder running counts.
//   Output channel (out_*): exactly one result item per command, showing the
//   drive state after that command.
//   Config port (cfg_*): index 0 target speed (also loads both wheel speeds),
//   index 1 minimum turn speed. Write only while idle.
// Sequencing:
//   Non-tick commands, and ticks while disabled or turning: result in the
//   cycle after the input handshake. A counted tick with equal deltas passes
//   through the compare state, then gives the result. Any other counted tick
//   runs the serial divider, one quotient bit per cycle, after the compare
//   state. One item at a time; in_tready is high only when idle and no result
//   waits, so a new item is not taken until the last result is taken.
// Reset: rst_n low clears the drive flags, stored counts and speeds; factors go
//   to 1.0, minimum turn speed to 50. Ready as soon as reset is released.
// Stall: a result is held in out_tdata until taken; no new item is accepted
//   meanwhile.

module two_wheel_speed_matcher_top import tws_pkg::*; #(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // operand_value, left_pulses, right_pulses, zero pad
  input  logic [((2*COUNT_WIDTH+OPV_W+7)/8)*8-1:0] in_tdata,
  // command
  input  logic [CMD_W-1:0] in_tuser,
  input  logic             in_tvalid,
  output logic             in_tready,
  // left_speed, right_speed, left_reverse, right_reverse, left_correction,
  // right_correction, is_enabled, is_turning, heading_bit, zero pad
  output logic [((2*FRACTION_BITS+23+7)/8)*8-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPEED_W-1:0]   cfg_wdata
);

  localparam int OUT_W  = ((2*FRACTION_BITS+23+7)/8)*8;
  localparam int FAC_W  = FRACTION_BITS + 1;
  localparam int OUT_USED = 2*FAC_W + 2*SPEED_W + 5;
  localparam logic [FAC_W-1:0] FACTOR_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [SPEED_W-1:0] target_r, target_nxt;
  logic [SPEED_W-1:0] min_turn_r, min_turn_nxt;
  logic [SPEED_W-1:0] speed_l_r, speed_l_nxt, speed_r_r, speed_r_nxt;
  logic rev_l_r, rev_l_nxt, rev_r_r, rev_r_nxt;
  logic dir_r, dir_nxt, enabled_r, enabled_nxt, turning_r, turning_nxt;
  logic [FAC_W-1:0] fac_l_r, fac_l_nxt, fac_r_r, fac_r_nxt;
  logic [COUNT_WIDTH-1:0] prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic [COUNT_WIDTH-1:0] dl_r, dl_nxt, dr_r, dr_nxt;
  logic side_left_r, side_left_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [OPV_W-1:0]       opv;
  logic [COUNT_WIDTH-1:0] lp, rp;
  logic                   accept;
  logic [SPEED_W-1:0]     half_speed, turn_speed;

  logic                     div_start, div_busy, div_done;
  logic [COUNT_WIDTH-1:0]   div_num, div_den;
  logic [FRACTION_BITS-1:0] div_quot;

  assign opv = in_tdata[OPV_W-1:0];
  assign lp  = in_tdata[OPV_W +: COUNT_WIDTH];
  assign rp  = in_tdata[OPV_W+COUNT_WIDTH +: COUNT_WIDTH];

  assign in_tready = rst_n && (state_r == S_IDLE) && !out_valid_r;
  assign accept    = in_tvalid && in_tready;

  assign half_speed = target_r >> 1;
  assign turn_speed = (half_speed < min_turn_r) ? min_turn_r : half_speed;

  assign div_start = (state_r == S_CMP) && (dl_r != dr_r);
  assign div_num   = (dl_r > dr_r) ? dr_r : dl_r;
  assign div_den   = (dl_r > dr_r) ? dl_r : dr_r;

  tws_divider #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    min_turn_nxt  = min_turn_r;
    speed_l_nxt   = speed_l_r;
    speed_r_nxt   = speed_r_r;
    rev_l_nxt     = rev_l_r;
    rev_r_nxt     = rev_r_r;
    dir_nxt       = dir_r;
    enabled_nxt   = enabled_r;
    turning_nxt   = turning_r;
    fac_l_nxt     = fac_l_r;
    fac_r_nxt     = fac_r_r;
    prev_l_nxt    = prev_l_r;
    prev_r_nxt    = prev_r_r;
    dl_nxt        = dl_r;
    dr_nxt        = dr_r;
    side_left_nxt = side_left_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_SPEED: begin
          target_nxt  = cfg_wdata;
          speed_l_nxt = cfg_wdata;
          speed_r_nxt = cfg_wdata;
        end
        REG_MIN_TURN_SPEED: min_turn_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_tuser)
            CMD_TICK: begin
              fac_l_nxt = FACTOR_ONE;
              fac_r_nxt = FACTOR_ONE;
              if (enabled_r && !turning_r) begin
                dl_nxt        = lp - prev_l_r;
                dr_nxt        = rp - prev_r_r;
                prev_l_nxt    = lp;
                prev_r_nxt    = rp;
                out_valid_nxt = 1'b0;
                state_nxt     = S_CMP;
              end
            end
            CMD_TURN: begin
              priority if (opv == SIDE_NONE) begin
                speed_l_nxt = target_r;
                speed_r_nxt = target_r;
                rev_l_nxt   = dir_r;
                rev_r_nxt   = dir_r;
                turning_nxt = 1'b0;
              end else if (opv == SIDE_LEFT || opv == SIDE_RIGHT) begin
                speed_l_nxt = turn_speed;
                speed_r_nxt = turn_speed;
                rev_l_nxt   = (opv == SIDE_LEFT) ? !dir_r : dir_r;
                rev_r_nxt   = (opv == SIDE_LEFT) ? dir_r : !dir_r;
                turning_nxt = 1'b1;
              end else begin
              end
            end
            CMD_FLIP: begin
              dir_nxt   = !dir_r;
              rev_l_nxt = !dir_r;
              rev_r_nxt = !dir_r;
            end
            CMD_SET_DIR: begin
              dir_nxt   = opv[0];
              rev_l_nxt = opv[0];
              rev_r_nxt = opv[0];
            end
            CMD_ENABLE:  enabled_nxt = 1'b1;
            CMD_DISABLE: enabled_nxt = 1'b0;
            CMD_TOGGLE:  enabled_nxt = !enabled_r;
            default: ;
          endcase
        end
      end
      S_CMP: begin
        side_left_nxt = dl_r > dr_r;
        if (dl_r == dr_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (side_left_r) begin
            fac_l_nxt = {1'b0, div_quot};
          end else begin
            fac_r_nxt = {1'b0, div_quot};
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    dl_r        <= dl_nxt;
    dr_r        <= dr_nxt;
    side_left_r <= side_left_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= '0;
      min_turn_r  <= MIN_TURN_RESET;
      speed_l_r   <= '0;
      speed_r_r   <= '0;
      rev_l_r     <= 1'b0;
      rev_r_r     <= 1'b0;
      dir_r       <= 1'b0;
      enabled_r   <= 1'b0;
      turning_r   <= 1'b0;
      fac_l_r     <= FACTOR_ONE;
      fac_r_r     <= FACTOR_ONE;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      min_turn_r  <= min_turn_nxt;
      speed_l_r   <= speed_l_nxt;
      speed_r_r   <= speed_r_nxt;
      rev_l_r     <= rev_l_nxt;
      rev_r_r     <= rev_r_nxt;
      dir_r       <= dir_nxt;
      enabled_r   <= enabled_nxt;
      turning_r   <= turning_nxt;
      fac_l_r     <= fac_l_nxt;
      fac_r_r     <= fac_r_nxt;
      prev_l_r    <= prev_l_nxt;
      prev_r_r    <= prev_r_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-OUT_USED){1'b0}}, dir_r, turning_r, enabled_r,
                       fac_r_r, fac_l_r, rev_r_r, rev_l_r, speed_r_r, speed_l_r};

  a_item_progresses: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r || state_r == S_CMP)
    else $error("accepted item neither answered nor sequenced");

  a_one_side_slowed: assert property (@(posedge clk) disable iff (!rst_n)
    !(fac_l_r != FACTOR_ONE && fac_r_r != FACTOR_ONE))
    else $error("both wheels slowed at once");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    fac_l_r <= FACTOR_ONE && fac_r_r <= FACTOR_ONE)
    else $error("correction factor above one");

  a_idle_tick_unity: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == CMD_TICK && (turning_r || !enabled_r)
    |=> fac_l_r == FACTOR_ONE && fac_r_r == FACTOR_ONE && $stable(prev_l_r))
    else $error("tick while idle drive changed factors or counts");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider running outside its state");

endmodule
